/* rtl/rat_pkg.sv */
// ----------------------------------------------------------------------------
// rat_pkg
// Shared types and constants of the retransmit and acknowledgement tracker.
// ----------------------------------------------------------------------------
package rat_pkg;

  // Table geometry and derived widths
  localparam int TableDepth = 64;
  localparam int IdxW       = (TableDepth > 1) ? $clog2(TableDepth) : 1;
  localparam int CntW       = $clog2(TableDepth + 1);

  // Fixed field widths
  localparam int IdW      = 32;
  localparam int TimeW    = 32;
  localparam int TimeoutW = 8;

  localparam logic [TimeoutW-1:0] TimeoutReset = 8'd2;

  // Operation codes of an input beat
  typedef enum logic [1:0] {
    OP_SEND = 2'd0,
    OP_ACK  = 2'd1,
    OP_TICK = 2'd2
  } op_e;

  // Result kinds
  typedef enum logic [2:0] {
    KIND_SENT    = 3'd0,
    KIND_FULL    = 3'd1,
    KIND_ACKED   = 3'd2,
    KIND_UNKNOWN = 3'd3,
    KIND_RETX    = 3'd4,
    KIND_NONE    = 3'd5
  } kind_e;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACK_SCAN,
    ST_ACK_MOVE,
    ST_TICK_COUNT,
    ST_TICK_EMIT
  } state_e;

endpackage

/* rtl/retransmit_ack_tracker.sv */
// ----------------------------------------------------------------------------
// retransmit_ack_tracker
// Sender-side table of unacknowledged messages: assigns ids on send, removes
// entries on acknowledgement and retransmits aged entries on a timer tick.
// ----------------------------------------------------------------------------
// A command is taken when start_i is high and busy_o is low. Every result beat
// is shown for exactly one cycle with valid_o high and cannot be held off;
// pending_o and transmissions_o give the totals after the whole command.
// The ids and stamps sit in two memories behind a single registered read
// port that scans one slot per cycle, which sets the command length: a send
// or a refused send finishes in the accept cycle (result in the next cycle),
// an ack scans the table up to the matching entry and then moves the tail
// entry into its slot, and a tick scans the table twice, since it counts the
// expired entries in a first pass and emits and restamps them, one beat per cycle, in a second pass.
// A new command may be started in the cycle that shows the final beat.
// The table needs no clearing pass after reset.
// ----------------------------------------------------------------------------
module retransmit_ack_tracker
  import rat_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  // command channel
  input  logic                start_i,
  output logic                busy_o,
  input  logic [1:0]          operation_i,
  input  logic [IdW-1:0]      ack_id_i,
  input  logic [TimeW-1:0]    now_seconds_i,
  // configuration
  input  logic                cfg_we_i,
  input  logic [TimeoutW-1:0] cfg_wdata_i,
  // result channel
  output logic                valid_o,
  output logic [2:0]          kind_o,
  output logic [IdW-1:0]      msg_id_o,
  output logic                last_o,
  output logic [6:0]          pending_o,
  output logic [31:0]         transmissions_o
);

  // Table memories
  logic [IdW-1:0]   ids_mem [TableDepth];
  logic [TimeW-1:0] st_mem  [TableDepth];

  state_e              state_q, state_d;
  logic [CntW-1:0]     rd_cnt_q, rd_cnt_d;
  logic                ev_valid_q, ev_valid_d;
  logic [IdxW-1:0]     ev_idx_q, ev_idx_d;
  logic [IdxW-1:0]     match_idx_q, match_idx_d;
  logic [CntW-1:0]     exp_cnt_q, exp_cnt_d;
  logic [CntW-1:0]     emit_cnt_q, emit_cnt_d;
  logic [TimeW-1:0]    now_q, now_d;
  logic [IdW-1:0]      ack_q, ack_d;
  logic [CntW-1:0]     pending_q, pending_d;
  logic [IdW-1:0]      next_id_q, next_id_d;
  logic [31:0]         tc_q, tc_d;
  logic [TimeoutW-1:0] timeout_q;

  logic                res_valid_q, res_valid_d;
  kind_e               res_kind_q, res_kind_d;
  logic [IdW-1:0]      res_id_q, res_id_d;
  logic                res_last_q, res_last_d;

  // memory port controls
  logic                rd_en;
  logic [IdxW-1:0]     rd_addr;
  logic [IdW-1:0]      id_rd_q;
  logic [TimeW-1:0]    st_rd_q;
  logic                ids_we, st_we;
  logic [IdxW-1:0]     wr_addr;
  logic [IdW-1:0]      ids_wdata;
  logic [TimeW-1:0]    st_wdata;

  // scan and compare helpers
  logic                accept;
  logic                scan_more;
  logic                scan_end;
  logic                hit;
  logic [TimeW-1:0]    age;
  logic                expired;
  logic                emit_last;
  logic                table_full;
  logic [CntW-1:0]     tail_cnt;
  logic [32:0]         tc_sum;
  logic [31:0]         tc_inc;
  logic [CntW-1:0]     emit_next;

  assign accept     = start_i && (state_q == ST_IDLE);
  assign scan_more  = rd_cnt_q < pending_q;
  assign scan_end   = !scan_more && !ev_valid_q;
  assign hit        = ev_valid_q && (id_rd_q == ack_q);
  assign age        = now_q - st_rd_q;
  assign expired    = ev_valid_q && (age >= {{(TimeW-TimeoutW){1'b0}}, timeout_q});
  assign emit_next  = emit_cnt_q + CntW'(1);
  assign emit_last  = (emit_next == exp_cnt_q);
  assign table_full = (pending_q == CntW'(TableDepth));
  assign tail_cnt   = pending_q - CntW'(1);
  assign tc_sum     = {1'b0, tc_q} + 33'(exp_cnt_q);
  assign tc_inc     = (tc_q == '1) ? tc_q : tc_q + 32'd1;

  // Next state
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          case (operation_i)
            OP_ACK:  state_d = ST_ACK_SCAN;
            OP_TICK: state_d = ST_TICK_COUNT;
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_ACK_SCAN: begin
        if (hit) begin
          state_d = ST_ACK_MOVE;
        end else if (scan_end) begin
          state_d = ST_IDLE;
        end
      end
      ST_ACK_MOVE: state_d = ST_IDLE;
      ST_TICK_COUNT: begin
        if (scan_end) begin
          state_d = (exp_cnt_q == '0) ? ST_IDLE : ST_TICK_EMIT;
        end
      end
      ST_TICK_EMIT: begin
        if (expired && emit_last) begin
          state_d = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // Datapath and memory controls
  always_comb begin
    rd_en       = 1'b0;
    rd_addr     = rd_cnt_q[IdxW-1:0];
    ids_we      = 1'b0;
    st_we       = 1'b0;
    wr_addr     = ev_idx_q;
    ids_wdata   = next_id_q;
    st_wdata    = now_q;
    rd_cnt_d    = rd_cnt_q;
    ev_valid_d  = 1'b0;
    ev_idx_d    = rd_cnt_q[IdxW-1:0];
    match_idx_d = match_idx_q;
    exp_cnt_d   = exp_cnt_q;
    emit_cnt_d  = emit_cnt_q;
    now_d       = now_q;
    ack_d       = ack_q;
    pending_d   = pending_q;
    next_id_d   = next_id_q;
    tc_d        = tc_q;
    res_valid_d = 1'b0;
    res_kind_d  = res_kind_q;
    res_id_d    = res_id_q;
    res_last_d  = 1'b1;

    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          now_d     = now_seconds_i;
          ack_d     = ack_id_i;
          rd_cnt_d  = '0;
          exp_cnt_d = '0;
          case (operation_i)
            OP_SEND: begin
              res_valid_d = 1'b1;
              res_id_d    = next_id_q;
              if (table_full) begin
                res_kind_d = KIND_FULL;
              end else begin
                // append at the tail slot
                res_kind_d = KIND_SENT;
                ids_we     = 1'b1;
                st_we      = 1'b1;
                wr_addr    = pending_q[IdxW-1:0];
                ids_wdata  = next_id_q;
                st_wdata   = now_seconds_i;
                pending_d  = pending_q + CntW'(1);
                next_id_d  = next_id_q + 32'd1;
                tc_d       = tc_inc;
              end
            end
            default: ;
          endcase
        end
      end

      ST_ACK_SCAN: begin
        if (hit) begin
          // fetch the tail entry to fill the freed slot
          rd_en       = 1'b1;
          rd_addr     = tail_cnt[IdxW-1:0];
          match_idx_d = ev_idx_q;
        end else if (scan_end) begin
          res_valid_d = 1'b1;
          res_kind_d  = KIND_UNKNOWN;
          res_id_d    = ack_q;
        end else if (scan_more) begin
          rd_en      = 1'b1;
          ev_valid_d = 1'b1;
          rd_cnt_d   = rd_cnt_q + CntW'(1);
        end
      end

      ST_ACK_MOVE: begin
        ids_we      = 1'b1;
        st_we       = 1'b1;
        wr_addr     = match_idx_q;
        ids_wdata   = id_rd_q;
        st_wdata    = st_rd_q;
        pending_d   = tail_cnt;
        res_valid_d = 1'b1;
        res_kind_d  = KIND_ACKED;
        res_id_d    = ack_q;
      end

      ST_TICK_COUNT: begin
        if (expired) begin
          exp_cnt_d = exp_cnt_q + CntW'(1);
        end
        if (scan_end) begin
          rd_cnt_d   = '0;
          emit_cnt_d = '0;
          if (exp_cnt_q == '0) begin
            res_valid_d = 1'b1;
            res_kind_d  = KIND_NONE;
            res_id_d    = '0;
          end else begin
            // settle the counter before the first retransmit beat
            tc_d = tc_sum[32] ? '1 : tc_sum[31:0];
          end
        end else if (scan_more) begin
          rd_en      = 1'b1;
          ev_valid_d = 1'b1;
          rd_cnt_d   = rd_cnt_q + CntW'(1);
        end
      end

      ST_TICK_EMIT: begin
        if (scan_more) begin
          rd_en      = 1'b1;
          ev_valid_d = 1'b1;
          rd_cnt_d   = rd_cnt_q + CntW'(1);
        end
        if (expired) begin
          // restamp and report the aged entry
          st_we       = 1'b1;
          wr_addr     = ev_idx_q;
          st_wdata    = now_q;
          emit_cnt_d  = emit_next;
          res_valid_d = 1'b1;
          res_kind_d  = KIND_RETX;
          res_id_d    = id_rd_q;
          res_last_d  = emit_last;
        end
      end

      default: ;
    endcase
  end

  // Table memories: one registered read port, one write port
  always_ff @(posedge clk_i) begin
    if (rd_en) begin
      id_rd_q <= ids_mem[rd_addr];
      st_rd_q <= st_mem[rd_addr];
    end
    if (ids_we) begin
      ids_mem[wr_addr] <= ids_wdata;
    end
    if (st_we) begin
      st_mem[wr_addr] <= st_wdata;
    end
  end

  // Control and bookkeeping registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      rd_cnt_q    <= '0;
      ev_valid_q  <= 1'b0;
      exp_cnt_q   <= '0;
      emit_cnt_q  <= '0;
      pending_q   <= '0;
      next_id_q   <= '0;
      tc_q        <= '0;
      timeout_q   <= TimeoutReset;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rd_cnt_q    <= rd_cnt_d;
      ev_valid_q  <= ev_valid_d;
      exp_cnt_q   <= exp_cnt_d;
      emit_cnt_q  <= emit_cnt_d;
      pending_q   <= pending_d;
      next_id_q   <= next_id_d;
      tc_q        <= tc_d;
      res_valid_q <= res_valid_d;
      if (cfg_we_i) begin
        timeout_q <= cfg_wdata_i;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    ev_idx_q    <= ev_idx_d;
    match_idx_q <= match_idx_d;
    now_q       <= now_d;
    ack_q       <= ack_d;
    res_kind_q  <= res_kind_d;
    res_id_q    <= res_id_d;
    res_last_q  <= res_last_d;
  end

  // Drive outputs
  assign busy_o          = (state_q != ST_IDLE);
  assign valid_o         = res_valid_q;
  assign kind_o          = res_kind_q;
  assign msg_id_o        = res_id_q;
  assign last_o          = res_last_q;
  assign pending_o       = 7'(pending_q);
  assign transmissions_o = tc_q;

`ifndef NO_ASSERTIONS
  a_pending_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pending_q <= CntW'(TableDepth))
    else $error("pending count above table depth");

  a_last_frees: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && last_o |-> !busy_o)
    else $error("final beat shown while command still busy");

  a_more_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    valid_o && !last_o |-> busy_o)
    else $error("non-final beat with sequencer idle");

  a_emit_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == ST_TICK_EMIT |-> emit_cnt_q < exp_cnt_q)
    else $error("retransmit pass emitted more than counted");
`endif

endmodule

/* dv/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the retransmit and acknowledgement tracker. A queue
// of commands feeds a falling-edge driver with random start gaps; a
// rising-edge monitor predicts the result beats of each accepted command and
// checks every beat, field by field, in order. The run covers directed corner
// cases, a full table with a maximal tick, and random traffic under several
// timeout settings.
// ----------------------------------------------------------------------------
module testbench;
  import rat_pkg::*;

  localparam logic [1:0] OpUndef = 2'd3;

  typedef struct {
    logic [1:0]  op;
    logic [31:0] ack;
    logic [31:0] now;
  } cmd_t;

  typedef struct {
    kind_e       kind;
    logic [31:0] msg_id;
    logic        last;
    logic [6:0]  pending;
    logic [31:0] tx;
  } beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                start_i = 1'b0;
  logic                busy_o;
  logic [1:0]          operation_i = '0;
  logic [IdW-1:0]      ack_id_i = '0;
  logic [TimeW-1:0]    now_seconds_i = '0;
  logic                cfg_we_i = 1'b0;
  logic [TimeoutW-1:0] cfg_wdata_i = '0;
  logic                valid_o;
  logic [2:0]          kind_o;
  logic [IdW-1:0]      msg_id_o;
  logic                last_o;
  logic [6:0]          pending_o;
  logic [31:0]         transmissions_o;

  // Shadow of the tracker state
  logic [31:0]         tbl_id [TableDepth];
  logic [31:0]         tbl_stamp [TableDepth];
  int                  tbl_count = 0;
  logic [31:0]         id_next = '0;
  logic [31:0]         tx_total = '0;
  logic [TimeoutW-1:0] timeout_cfg = TimeoutReset;

  cmd_t        cmd_q [$];
  beat_t       expected_q [$];
  beat_t       want;
  cmd_t        cur_cmd;
  logic        cmd_taken = 1'b0;
  bit          no_idle = 1'b0;
  int          gap_left = 0;
  logic [31:0] clock_now = 32'd1000;
  int          fail_count = 0;
  int          cmds_taken = 0;
  int          cmds_ignored = 0;
  int          beats_checked = 0;
  int          retx_seen = 0;
  int          full_seen = 0;

  retransmit_ack_tracker DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .operation_i    (operation_i),
    .ack_id_i       (ack_id_i),
    .now_seconds_i  (now_seconds_i),
    .cfg_we_i       (cfg_we_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .valid_o        (valid_o),
    .kind_o         (kind_o),
    .msg_id_o       (msg_id_o),
    .last_o         (last_o),
    .pending_o      (pending_o),
    .transmissions_o(transmissions_o)
  );

  always #2 clk_i = ~clk_i;

  task automatic note_failure(string msg);
    fail_count++;
    if (fail_count <= 10) $display("MISMATCH @%0t: %s", $time, msg);
  endtask

  function automatic void count_tx();
    if (tx_total != 32'hFFFF_FFFF) tx_total++;
  endfunction

  // Apply one command to the shadow table and queue the beats it yields
  function automatic void track_command(logic [1:0] op, logic [31:0] ack,
                                        logic [31:0] now);
    beat_t       beats [$];
    beat_t       b;
    int          hit;
    logic [31:0] age;
    hit = -1;
    case (op)
      OP_SEND: begin
        b.msg_id = id_next;
        if (tbl_count == TableDepth) begin
          b.kind = KIND_FULL;
        end else begin
          tbl_id[tbl_count] = id_next;
          tbl_stamp[tbl_count] = now;
          tbl_count++;
          b.kind = KIND_SENT;
          id_next++;
          count_tx();
        end
        beats.push_back(b);
      end
      OP_ACK: begin
        for (int i = 0; i < tbl_count; i++) begin
          if (hit < 0 && tbl_id[i] == ack) hit = i;
        end
        // Move the tail entry into the freed slot
        if (hit >= 0) begin
          tbl_count--;
          tbl_id[hit] = tbl_id[tbl_count];
          tbl_stamp[hit] = tbl_stamp[tbl_count];
        end
        b.kind = (hit >= 0) ? KIND_ACKED : KIND_UNKNOWN;
        b.msg_id = ack;
        beats.push_back(b);
      end
      OP_TICK: begin
        for (int i = 0; i < tbl_count; i++) begin
          age = now - tbl_stamp[i];
          if (age >= 32'(timeout_cfg)) begin
            tbl_stamp[i] = now;
            count_tx();
            b.kind = KIND_RETX;
            b.msg_id = tbl_id[i];
            beats.push_back(b);
          end
        end
        if (beats.size() == 0) begin
          b.kind = KIND_NONE;
          b.msg_id = '0;
          beats.push_back(b);
        end
      end
      default: return;
    endcase
    // Stamp totals after the whole command on every beat
    foreach (beats[k]) begin
      beats[k].last = (k == beats.size() - 1);
      beats[k].pending = 7'(tbl_count);
      beats[k].tx = tx_total;
      expected_q.push_back(beats[k]);
    end
  endfunction

  // Driver: present commands at the falling edge, with random start gaps
  always @(negedge clk_i) begin
    if (rst_ni && !(start_i && !cmd_taken)) begin
      if (start_i && !no_idle && $urandom_range(0, 4) == 0) begin
        gap_left = $urandom_range(1, 14);
      end
      if (gap_left > 0) begin
        gap_left--;
        start_i <= 1'b0;
      end else if (cmd_q.size() != 0) begin
        cur_cmd = cmd_q.pop_front();
        start_i <= 1'b1;
        operation_i <= cur_cmd.op;
        ack_id_i <= cur_cmd.ack;
        now_seconds_i <= cur_cmd.now;
      end else begin
        start_i <= 1'b0;
      end
    end
  end

  // Monitor: check result beats, track config writes and accepted commands
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (valid_o) begin
        beats_checked++;
        if (expected_q.size() == 0) begin
          note_failure($sformatf("unexpected beat kind=%0d id=%h", kind_o, msg_id_o));
        end else begin
          want = expected_q.pop_front();
          if (kind_o !== want.kind || msg_id_o !== want.msg_id || last_o !== want.last ||
              pending_o !== want.pending || transmissions_o !== want.tx) begin
            note_failure({
              $sformatf("exp kind=%0d id=%h last=%0b pend=%0d tx=%0d",
                        want.kind, want.msg_id, want.last, want.pending, want.tx),
              $sformatf(", got kind=%0d id=%h last=%0b pend=%0d tx=%0d",
                        kind_o, msg_id_o, last_o, pending_o, transmissions_o)});
          end
          if (want.kind == KIND_RETX) retx_seen++;
          if (want.kind == KIND_FULL) full_seen++;
        end
      end
      if (cfg_we_i) timeout_cfg = cfg_wdata_i;
      if (start_i && !busy_o) begin
        if (operation_i == OpUndef) cmds_ignored++;
        else cmds_taken++;
        track_command(operation_i, ack_id_i, now_seconds_i);
      end
    end
    cmd_taken <= rst_ni && start_i && !busy_o;
  end

  task automatic push_cmd(logic [1:0] op, logic [31:0] ack, logic [31:0] now);
    cmd_t c;
    c.op = op;
    c.ack = ack;
    c.now = now;
    cmd_q.push_back(c);
  endtask

  // Hold until nothing is queued, in flight or expected, then let the block settle
  task automatic wait_idle();
    @(posedge clk_i);
    while (cmd_q.size() != 0 || start_i || expected_q.size() != 0) @(posedge clk_i);
    repeat (16) @(posedge clk_i);
  endtask

  task automatic set_timeout(logic [TimeoutW-1:0] value);
    wait_idle();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Feed random traffic one command at a time, acking mostly live ids
  task automatic queue_random(int n);
    cmd_t c;
    int   made;
    int   pick;
    made = 0;
    while (made < n) begin
      while (cmd_q.size() != 0) @(posedge clk_i);
      if ($urandom_range(0, 24) == 0) clock_now = $urandom;
      else clock_now += $urandom_range(0, 3);
      c.now = clock_now;
      c.ack = $urandom;
      pick = $urandom_range(0, 99);
      if (pick < 40) begin
        c.op = OP_SEND;
      end else if (pick < 75) begin
        c.op = OP_ACK;
        if (tbl_count > 0 && $urandom_range(0, 99) < 80) begin
          c.ack = tbl_id[$urandom_range(0, tbl_count - 1)];
        end
      end else if (pick < 95) begin
        c.op = OP_TICK;
      end else begin
        c.op = OpUndef;
      end
      cmd_q.push_back(c);
      if (c.op != OpUndef) made++;
    end
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Directed: empty table, clock wrap, middle and head removal, future stamps
    push_cmd(OP_TICK, 32'h0, 32'h0);
    push_cmd(OP_ACK, 32'hFFFF_FFFF, 32'h0);
    push_cmd(OpUndef, 32'hA5A5_A5A5, 32'h5A5A_5A5A);
    push_cmd(OP_SEND, 32'h0, 32'h0);
    push_cmd(OP_SEND, 32'h0, 32'h1);
    push_cmd(OP_SEND, 32'h0, 32'hFFFF_FFFE);
    push_cmd(OP_SEND, 32'h0, 32'hFFFF_FFFF);
    push_cmd(OP_TICK, 32'h0, 32'h1);
    push_cmd(OP_TICK, 32'h0, 32'h1);
    push_cmd(OP_ACK, 32'd1, 32'h1);
    push_cmd(OP_ACK, 32'd1, 32'h1);
    push_cmd(OP_ACK, 32'd0, 32'h1);
    push_cmd(OP_TICK, 32'h0, 32'h0);
    push_cmd(OP_SEND, 32'h0, 32'h8000_0000);
    push_cmd(OP_TICK, 32'h0, 32'h8000_0002);
    push_cmd(OP_ACK, 32'd4, 32'h8000_0002);
    push_cmd(OP_ACK, 32'd3, 32'h8000_0002);
    push_cmd(OP_ACK, 32'd2, 32'h8000_0002);
    push_cmd(OP_ACK, 32'd0, 32'h8000_0002);
    push_cmd(OpUndef, 32'h0, 32'hFFFF_FFFF);

    // Longest timeout: fill the table past full, then expire every entry at once
    set_timeout(8'd255);
    repeat (TableDepth - tbl_count + 3) push_cmd(OP_SEND, $urandom, clock_now);
    push_cmd(OP_TICK, $urandom, clock_now + 32'd254);
    push_cmd(OP_TICK, 32'h0, clock_now + 32'd255);
    clock_now += 32'd255;
    queue_random(30);

    set_timeout(8'd0);
    queue_random(20);
    set_timeout(8'd1);
    queue_random(20);
    set_timeout(8'($urandom_range(3, 12)));
    queue_random(20);

    // Close with back-to-back commands
    wait_idle();
    no_idle = 1'b1;
    queue_random(20);

    while (cmd_q.size() != 0 || start_i) @(posedge clk_i);
    for (int w = 0; w < 2000 && expected_q.size() != 0; w++) @(posedge clk_i);
    repeat (150) @(posedge clk_i);
    if (expected_q.size() != 0) begin
      note_failure($sformatf("%0d expected beats never arrived", expected_q.size()));
    end

    $display("Ran %0d commands plus %0d undefined ones under timeouts 2, 255, 0, 1 and random.",
             cmds_taken, cmds_ignored);
    $display("Checked %0d result beats: %0d retransmits, %0d refused sends, %0d failures.",
             beats_checked, retx_seen, full_seen, fail_count);
    if (fail_count == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

  // Watchdog: stop a hung run
  initial begin
    #2_000_000;
    $display("Timeout: %0d beats still expected, %0d commands queued",
             expected_q.size(), cmd_q.size());
    $display("CHECKS FAILED");
    $finish;
  end

endmodule

/* sim.f */
rtl/rat_pkg.sv
rtl/retransmit_ack_tracker.sv
dv/testbench.sv
